@@ rtl/rsd_pkg.sv @@
`timescale 1ns / 1ps

package rsd_pkg;

   localparam int unsigned KIND_W  = 3;
   localparam int unsigned ECODE_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TOPIC   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

   // error codes
   localparam logic [ECODE_W-1:0] ERR_NONE        = 2'd0;
   localparam logic [ECODE_W-1:0] ERR_BAD_MAGIC   = 2'd1;
   localparam logic [ECODE_W-1:0] ERR_BAD_VERSION = 2'd2;
   localparam logic [ECODE_W-1:0] ERR_TOO_LONG    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_WORD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [15:0] MAGIC_RESET       = 16'h0000;
   localparam logic [7:0]  VERSION_RESET     = 8'h01;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'h0010_0000;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ECODE_W-1:0] error_code;
      logic [7:0]         data_byte;
      logic [7:0]         command;
      logic [63:0]        frame_id;
      logic [15:0]        flags;
      logic [15:0]        topic_count;
      logic [31:0]        body_len;
      logic               frame_end;
   } result_type;

   typedef struct packed {
      logic [15:0] magic_word;
      logic [7:0]  expected_version;
      logic [31:0] max_payload;
   } cfg_type;

endpackage

@@ rtl/rsd_ifs.sv @@
`timescale 1ns / 1ps

interface rsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [1:0]  error_code;
   logic [7:0]  data_byte;
   logic [7:0]  command;
   logic [63:0] frame_id;
   logic [15:0] flags;
   logic [15:0] topic_count;
   logic [31:0] body_len;
   logic        frame_end;

   modport source (output valid, output kind, output error_code, output data_byte,
                   output command, output frame_id, output flags, output topic_count,
                   output body_len, output frame_end, input ready);
   modport sink   (input valid, input kind, input error_code, input data_byte,
                   input command, input frame_id, input flags, input topic_count,
                   input body_len, input frame_end, output ready);
endinterface

@@ rtl/request_stream_deframer.sv @@
`timescale 1ns / 1ps

// Request stream deframer.
// req_chan carries one stream byte per beat. rsp_chan carries one result per
// beat: a header (command, id, flags, topic length), each topic byte, the
// payload length, then each payload byte; frame_end marks the last result of a
// frame. A bad magic word, version or oversized payload length gives an error
// result and parsing restarts at the next byte; the receiver drops that frame.
// csr_we/csr_index/csr_wdata write magic word, version and payload limit;
// write them only while the block is idle.
// Throughput: one byte per cycle while req_chan.ready is high. Each result is
// registered in the output buffer before it appears on rsp_chan; the parser
// updates all its state once per accepted byte.
// A two-entry output buffer sits before rsp_chan: req_chan.ready drops only
// when both entries hold results, so a stalled receiver holds the input back
// after two pending results, and nothing is lost.
// Reset (synchronous) empties the buffer, returns the parser to the start of a
// frame and loads the register reset values.
module request_stream_deframer (
   input  logic                           clock,
   input  logic                           reset,
   rsd_req_if.sink                        req_chan,
   rsd_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [rsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rsd_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type out_res;
   logic       res_valid;
   logic       can_push;
   logic       advance;

   assign advance       = req_chan.valid & can_push;
   assign req_chan.ready = can_push;

   rsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_byte   (req_chan.in_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   rsd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_push  (can_push),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_res)
   );

   assign rsp_chan.kind        = out_res.kind;
   assign rsp_chan.error_code  = out_res.error_code;
   assign rsp_chan.data_byte   = out_res.data_byte;
   assign rsp_chan.command     = out_res.command;
   assign rsp_chan.frame_id    = out_res.frame_id;
   assign rsp_chan.flags       = out_res.flags;
   assign rsp_chan.topic_count = out_res.topic_count;
   assign rsp_chan.body_len    = out_res.body_len;
   assign rsp_chan.frame_end   = out_res.frame_end;

endmodule

@@ rtl/rsd_csr.sv @@
`timescale 1ns / 1ps

module rsd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rsd_pkg::cfg_type               cfg
);
   import rsd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAGIC_WORD:  cfg_in.magic_word       = csr_wdata[15:0];
            CSR_EXP_VERSION: cfg_in.expected_version = csr_wdata[7:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload      = csr_wdata[31:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word       <= MAGIC_RESET;
         cfg_ff.expected_version <= VERSION_RESET;
         cfg_ff.max_payload      <= MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/rsd_parser.sv @@
`timescale 1ns / 1ps

module rsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          in_byte,
   input  rsd_pkg::cfg_type    cfg,
   output logic                res_valid,
   output rsd_pkg::result_type res
);
   import rsd_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_TOPIC   = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [3:0] POS_MAGIC_HI = 4'd0;
   localparam logic [3:0] POS_MAGIC_LO = 4'd1;
   localparam logic [3:0] POS_VERSION  = 4'd2;
   localparam logic [3:0] POS_COMMAND  = 4'd3;
   localparam logic [3:0] POS_FLAGS_HI = 4'd12;
   localparam logic [3:0] POS_FLAGS_LO = 4'd13;
   localparam logic [3:0] POS_TLEN_HI  = 4'd14;
   localparam logic [3:0] POS_TLEN_LO  = 4'd15;
   localparam logic [3:0] POS_LEN_LAST = 4'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] id_ff, id_in;
   logic [15:0] flags_ff, flags_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  magic_hi_ff, magic_hi_in;
   logic [31:0] len_ff, len_in;

   logic        emit;
   logic [31:0] len_next;
   logic [15:0] tlen_next;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      id_in       = id_ff;
      flags_in    = flags_ff;
      cmd_in      = cmd_ff;
      magic_hi_in = magic_hi_ff;
      len_in      = len_ff;
      emit        = 1'b0;
      res         = '0;
      len_next    = {len_ff[23:0], in_byte};
      tlen_next   = {rem_ff[7:0], in_byte};

      case (phase_ff)
         PH_TOPIC: begin
            emit          = 1'b1;
            res.kind      = KIND_TOPIC;
            res.data_byte = in_byte;
            rem_in        = rem_ff - 32'd1;
            if (rem_ff == 32'd1) begin
               phase_in = PH_LENGTH;
               pos_in   = '0;
               len_in   = '0;
            end
         end
         PH_LENGTH: begin
            len_in = len_next;
            if (pos_ff != POS_LEN_LAST) begin
               pos_in = pos_ff + 4'd1;
            end else if (len_next > cfg.max_payload) begin
               emit           = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TOO_LONG;
               phase_in       = PH_HEADER;
               pos_in         = '0;
               rem_in         = '0;
               len_in         = '0;
            end else begin
               emit         = 1'b1;
               res.kind     = KIND_LENGTH;
               res.body_len = len_next;
               pos_in       = '0;
               if (len_next == 32'd0) begin
                  res.frame_end = 1'b1;
                  phase_in      = PH_HEADER;
                  rem_in        = '0;
                  len_in        = '0;
               end else begin
                  phase_in = PH_PAYLOAD;
                  rem_in   = len_next;
               end
            end
         end
         PH_PAYLOAD: begin
            emit          = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = in_byte;
            rem_in        = rem_ff - 32'd1;
            if (rem_ff == 32'd1) begin
               res.frame_end = 1'b1;
               phase_in      = PH_HEADER;
               pos_in        = '0;
               rem_in        = '0;
               len_in        = '0;
            end
         end
         default: begin
            pos_in = pos_ff + 4'd1;
            case (pos_ff)
               POS_MAGIC_HI: magic_hi_in = in_byte;
               POS_MAGIC_LO: begin
                  if ({magic_hi_ff, in_byte} != cfg.magic_word) begin
                     emit           = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_BAD_MAGIC;
                     pos_in         = '0;
                     rem_in         = '0;
                     len_in         = '0;
                  end
               end
               POS_VERSION: begin
                  if (in_byte != cfg.expected_version) begin
                     emit           = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_BAD_VERSION;
                     pos_in         = '0;
                     rem_in         = '0;
                     len_in         = '0;
                  end
               end
               POS_COMMAND: begin
                  cmd_in = in_byte;
                  id_in  = '0;
               end
               POS_FLAGS_HI, POS_FLAGS_LO: flags_in = {flags_ff[7:0], in_byte};
               POS_TLEN_HI: rem_in = {24'd0, in_byte};
               POS_TLEN_LO: begin
                  emit            = 1'b1;
                  res.kind        = KIND_HEADER;
                  res.command     = cmd_ff;
                  res.frame_id    = id_ff;
                  res.flags       = flags_ff;
                  res.topic_count = tlen_next;
                  rem_in          = {16'd0, tlen_next};
                  pos_in          = '0;
                  len_in          = '0;
                  phase_in        = (tlen_next == 16'd0) ? PH_LENGTH : PH_TOPIC;
               end
               default: id_in = {id_ff[55:0], in_byte};
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         rem_ff      <= '0;
         len_ff      <= '0;
         id_ff       <= '0;
         flags_ff    <= '0;
         cmd_ff      <= '0;
         magic_hi_ff <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         rem_ff      <= rem_in;
         len_ff      <= len_in;
         id_ff       <= id_in;
         flags_ff    <= flags_in;
         cmd_ff      <= cmd_in;
         magic_hi_ff <= magic_hi_in;
      end
   end

   assign res_valid = advance & emit;

endmodule

@@ rtl/rsd_out_skid.sv @@
`timescale 1ns / 1ps

module rsd_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rsd_pkg::result_type push_data,
   output logic                can_push,
   output logic                out_valid,
   input  logic                out_ready,
   output rsd_pkg::result_type out_data
);
   import rsd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

@@ rtl/rsd_checker.sv @@
`timescale 1ns / 1ps

module rsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [1:0] rsp_error_code,
   input logic       rsp_frame_end
);
   import rsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_error_code != ERR_NONE && !rsp_frame_end)
      else $error("error result without code or with frame end");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("error code on a non-error result");

   a_no_result_without_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !rsp_valid || $past(req_valid && req_ready))
      else $error("result appeared with no accepted byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule

bind request_stream_deframer rsd_checker u_rsd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_error_code (rsp_chan.error_code),
   .rsp_frame_end  (rsp_chan.frame_end)
);
